[rtl/tlc_pkg.sv]
// Shared types and constants of the two-way traffic light controller.
package tlc_pkg;

  localparam int unsigned DUR_W = 7;
  localparam int unsigned TIMER_W = 10;
  localparam logic [DUR_W-1:0] MAX_DURATION = 7'd99;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COUNT_PERIOD = 2'd0;
  localparam logic [1:0] CFG_BLINK_PERIOD = 2'd1;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd2;
  localparam logic [1:0] CFG_SCAN_PERIOD = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT = 3'd0,
    ST_RUN = 3'd1,
    ST_EDIT_RED = 3'd2,
    ST_EDIT_YELLOW = 3'd3,
    ST_EDIT_GREEN = 3'd4,
    ST_INCR = 3'd5,
    ST_AUTO = 3'd6,
    ST_COMMIT = 3'd7
  } state_t;

  typedef enum logic [1:0] {
    COL_RED = 2'd0,
    COL_YELLOW = 2'd1,
    COL_GREEN = 2'd2
  } colour_t;

  // One result beat before the display values are split into digits.
  typedef struct packed {
    state_t mode;
    logic [5:0] lamps;
    logic scan;
    logic [DUR_W-1:0] left_value;
    logic [DUR_W-1:0] right_value;
  } result_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } fifo_status_t;

endpackage

[rtl/tlc_if.sv]
// Handshake interfaces for the input and result channels.
interface tlc_in_if;
  logic valid;
  logic ready;
  logic mode_button;
  logic increment_button;
  logic increment_held_long;
  logic commit_button;

  modport source (output valid, mode_button, increment_button, increment_held_long,
                  commit_button, input ready);
  modport sink (input valid, mode_button, increment_button, increment_held_long,
                commit_button, output ready);
endinterface

interface tlc_out_if;
  logic valid;
  logic ready;
  logic [2:0] mode_code;
  logic [2:0] way1_lamps;
  logic [2:0] way2_lamps;
  logic scan_digit;
  logic [3:0] left_tens;
  logic [3:0] left_units;
  logic [3:0] right_tens;
  logic [3:0] right_units;

  modport source (output valid, mode_code, way1_lamps, way2_lamps, scan_digit, left_tens,
                  left_units, right_tens, right_units, input ready);
  modport sink (input valid, mode_code, way1_lamps, way2_lamps, scan_digit, left_tens,
                left_units, right_tens, right_units, output ready);
endinterface

[rtl/tlc_result_fifo.sv]
// Two-entry result queue that parts the state update from the result channel.
module tlc_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tlc_pkg::result_t      push_data,
  input  logic                  pop,
  output tlc_pkg::result_t      head,
  output tlc_pkg::fifo_status_t status
);

  tlc_pkg::result_t entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign head              = entry[rd_ptr];
  assign status.full       = (fill == 2'd2);
  assign status.head_valid = (fill != 2'd0);

endmodule

[rtl/two_way_traffic_light_controller_top.sv]
// Top level of the two-way traffic light controller.
//
// Each input beat is one base tick carrying the debounced button levels; the block answers
// every beat with exactly one result beat giving the mode, both ways' lamp masks, the scanned
// digit and the four display digits. The whole state update for a tick happens in the cycle
// the beat is accepted, so a new beat may be taken every clock cycle; results then pass
// through a two-entry queue, which lets two beats be taken while the result side stalls
// before input ready drops. Each result is queued in the cycle its beat is accepted. The four
// period registers are written through the plain write port and count in base ticks; a period
// of zero behaves as a period of one. After reset the controller sits in its init state and
// loads the default durations (red 5, yellow 2, green 3) on the first tick.
module two_way_traffic_light_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  tlc_in_if.sink                        req,
  tlc_out_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tlc_pkg::TIMER_W-1:0]   cfg_data
);

  localparam int unsigned DW = tlc_pkg::DUR_W;
  localparam int unsigned TW = tlc_pkg::TIMER_W;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // Configuration registers.
  logic [TW-1:0] count_period;
  logic [TW-1:0] blink_period;
  logic [TW-1:0] repeat_period;
  logic [TW-1:0] scan_period;

  // Controller state and its next values.
  tlc_pkg::state_t  state, state_next;
  tlc_pkg::colour_t edit_colour, edit_colour_next;
  logic             mode_latch, mode_latch_next;
  logic             first_done, first_done_next;
  logic [DW-1:0]    committed [3];
  logic [DW-1:0]    committed_next [3];
  logic [DW-1:0]    temp [3];
  logic [DW-1:0]    temp_next [3];
  tlc_pkg::colour_t way1_colour, way1_colour_next;
  tlc_pkg::colour_t way2_colour, way2_colour_next;
  logic [DW-1:0]    way1_count [3];
  logic [DW-1:0]    way1_count_next [3];
  logic [DW-1:0]    way2_count [3];
  logic [DW-1:0]    way2_count_next [3];
  logic [5:0]       lamps, lamps_next;
  logic [TW-1:0]    count_timer, count_timer_next;
  logic [TW-1:0]    blink_timer, blink_timer_next;
  logic [TW-1:0]    repeat_timer, repeat_timer_next;
  logic [TW-1:0]    scan_timer, scan_timer_next;
  logic             scan_index, scan_index_next;

  logic                  accept;
  tlc_pkg::result_t      result;
  tlc_pkg::result_t      head;
  tlc_pkg::fifo_status_t fifo_status;
  tlc_pkg::colour_t      cur;
  tlc_pkg::colour_t      disp_colour;
  digits_t               left_digits;
  digits_t               right_digits;

  function automatic logic [5:0] lamp_bit(input logic way, input tlc_pkg::colour_t col);
    lamp_bit = 6'd1 << (way ? 3'd3 + 3'(col) : 3'(col));
  endfunction

  function automatic tlc_pkg::colour_t next_colour(input tlc_pkg::colour_t col);
    unique case (col)
      tlc_pkg::COL_RED:    next_colour = tlc_pkg::COL_YELLOW;
      tlc_pkg::COL_YELLOW: next_colour = tlc_pkg::COL_GREEN;
      default:             next_colour = tlc_pkg::COL_RED;
    endcase
  endfunction

  function automatic tlc_pkg::colour_t prev_colour(input tlc_pkg::colour_t col);
    unique case (col)
      tlc_pkg::COL_YELLOW: prev_colour = tlc_pkg::COL_RED;
      tlc_pkg::COL_GREEN:  prev_colour = tlc_pkg::COL_YELLOW;
      default:             prev_colour = tlc_pkg::COL_GREEN;
    endcase
  endfunction

  function automatic logic [TW-1:0] tick_down(input logic [TW-1:0] t);
    tick_down = (t == '0) ? '0 : t - TW'(1);
  endfunction

  function automatic logic [DW-1:0] bump(input logic [DW-1:0] v);
    bump = (v >= tlc_pkg::MAX_DURATION) ? DW'(1) : v + DW'(1);
  endfunction

  // Values stay below 100, so a multiply by 103 and a shift by ten give the tens digit.
  function automatic digits_t split_digits(input logic [DW-1:0] v);
    logic [13:0]   prod;
    logic [DW-1:0] rest;
    digits_t       d;
    prod    = 14'(v) * 14'd103;
    d.tens  = prod[13:10];
    rest    = v - DW'(d.tens) * DW'(10);
    d.units = rest[3:0];
    split_digits = d;
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = !fifo_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_period  <= TW'(100);
      blink_period  <= TW'(25);
      repeat_period <= TW'(50);
      scan_period   <= TW'(25);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlc_pkg::CFG_COUNT_PERIOD:  count_period  <= cfg_data;
        tlc_pkg::CFG_BLINK_PERIOD:  blink_period  <= cfg_data;
        tlc_pkg::CFG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default:                    scan_period   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tlc_pkg::ST_INIT;
      edit_colour  <= tlc_pkg::COL_RED;
      mode_latch   <= 1'b0;
      first_done   <= 1'b0;
      committed[0] <= DW'(5);
      committed[1] <= DW'(2);
      committed[2] <= DW'(3);
      temp[0]      <= DW'(5);
      temp[1]      <= DW'(2);
      temp[2]      <= DW'(3);
      way1_colour  <= tlc_pkg::COL_RED;
      way2_colour  <= tlc_pkg::COL_YELLOW;
      way1_count[0] <= DW'(5);
      way1_count[1] <= DW'(2);
      way1_count[2] <= DW'(3);
      way2_count[0] <= DW'(5);
      way2_count[1] <= DW'(2);
      way2_count[2] <= DW'(3);
      lamps        <= '0;
      count_timer  <= '0;
      blink_timer  <= '0;
      repeat_timer <= '0;
      scan_timer   <= '0;
      scan_index   <= 1'b0;
    end else if (accept) begin
      state        <= state_next;
      edit_colour  <= edit_colour_next;
      mode_latch   <= mode_latch_next;
      first_done   <= first_done_next;
      committed    <= committed_next;
      temp         <= temp_next;
      way1_colour  <= way1_colour_next;
      way2_colour  <= way2_colour_next;
      way1_count   <= way1_count_next;
      way2_count   <= way2_count_next;
      lamps        <= lamps_next;
      count_timer  <= count_timer_next;
      blink_timer  <= blink_timer_next;
      repeat_timer <= repeat_timer_next;
      scan_timer   <= scan_timer_next;
      scan_index   <= scan_index_next;
    end
  end

  // One tick of the controller: timers count down first, then the state machine steps.
  always_comb begin
    state_next        = state;
    edit_colour_next  = edit_colour;
    mode_latch_next   = mode_latch;
    first_done_next   = first_done;
    committed_next    = committed;
    temp_next         = temp;
    way1_colour_next  = way1_colour;
    way2_colour_next  = way2_colour;
    way1_count_next   = way1_count;
    way2_count_next   = way2_count;
    lamps_next        = lamps;
    count_timer_next  = tick_down(count_timer);
    blink_timer_next  = tick_down(blink_timer);
    repeat_timer_next = tick_down(repeat_timer);
    scan_timer_next   = tick_down(scan_timer);
    scan_index_next   = scan_index;
    cur               = edit_colour;

    unique case (state)
      tlc_pkg::ST_INIT: begin
        temp_next        = committed;
        way1_count_next  = committed;
        way2_count_next  = committed;
        way1_colour_next = tlc_pkg::COL_RED;
        way2_colour_next = tlc_pkg::COL_YELLOW;
        lamps_next       = lamp_bit(1'b0, tlc_pkg::COL_RED)
                         | lamp_bit(1'b1, tlc_pkg::COL_YELLOW);
        scan_index_next  = 1'b0;
        scan_timer_next  = scan_period;
        count_timer_next = count_period;
        state_next       = tlc_pkg::ST_RUN;
      end
      tlc_pkg::ST_RUN: begin
        if (scan_timer_next == '0) begin
          scan_timer_next = scan_period;
          scan_index_next = ~scan_index;
        end
        if (count_timer_next == '0) begin
          count_timer_next = count_period;
          if (way1_count[way1_colour] <= DW'(1)) begin
            way1_count_next[way1_colour] = committed[way1_colour];
            way1_colour_next             = next_colour(way1_colour);
          end else begin
            way1_count_next[way1_colour] = way1_count[way1_colour] - DW'(1);
          end
          if (way2_count[way2_colour] <= DW'(1)) begin
            way2_count_next[way2_colour] = committed[way2_colour];
            way2_colour_next             = next_colour(way2_colour);
          end else begin
            way2_count_next[way2_colour] = way2_count[way2_colour] - DW'(1);
          end
          lamps_next = (lamps_next | lamp_bit(1'b0, way1_colour_next))
                     & ~lamp_bit(1'b0, prev_colour(way1_colour_next));
          lamps_next = (lamps_next | lamp_bit(1'b1, way2_colour_next))
                     & ~lamp_bit(1'b1, prev_colour(way2_colour_next));
        end
        if (!mode_latch) begin
          if (req.mode_button) begin
            state_next       = tlc_pkg::ST_EDIT_RED;
            mode_latch_next  = 1'b1;
            blink_timer_next = blink_period;
            temp_next        = committed;
            lamps_next       = '0;
          end
        end else if (!req.mode_button) begin
          mode_latch_next = 1'b0;
        end
      end
      tlc_pkg::ST_EDIT_RED, tlc_pkg::ST_EDIT_YELLOW, tlc_pkg::ST_EDIT_GREEN: begin
        cur = tlc_pkg::colour_t'(2'(state - tlc_pkg::ST_EDIT_RED));
        if (blink_timer_next == '0) begin
          blink_timer_next = blink_period;
          lamps_next       = lamps ^ (lamp_bit(1'b0, cur) | lamp_bit(1'b1, cur));
        end
        if (scan_timer_next == '0) begin
          scan_timer_next = scan_period;
          scan_index_next = ~scan_index;
        end
        if (!mode_latch) begin
          if (req.mode_button) begin
            state_next      = (cur == tlc_pkg::COL_GREEN) ? tlc_pkg::ST_INIT
                                                          : tlc_pkg::state_t'(state + 3'd1);
            mode_latch_next = 1'b1;
            lamps_next      = '0;
          end
        end else if (!req.mode_button) begin
          mode_latch_next = 1'b0;
        end
        // Commit overrides a mode press, and an increment overrides both.
        if (req.commit_button) begin
          state_next       = tlc_pkg::ST_COMMIT;
          edit_colour_next = cur;
        end
        if (req.increment_button) begin
          state_next       = tlc_pkg::ST_INCR;
          edit_colour_next = cur;
          first_done_next  = 1'b0;
        end
      end
      tlc_pkg::ST_INCR: begin
        if (blink_timer_next == '0) begin
          blink_timer_next = blink_period;
          lamps_next       = lamps ^ (lamp_bit(1'b0, cur) | lamp_bit(1'b1, cur));
        end
        if (scan_timer_next == '0) begin
          scan_timer_next = scan_period;
          scan_index_next = ~scan_index;
        end
        if (req.increment_held_long) begin
          state_next        = tlc_pkg::ST_AUTO;
          repeat_timer_next = repeat_period;
        end else if (!req.increment_button) begin
          state_next = tlc_pkg::state_t'(tlc_pkg::ST_EDIT_RED + 3'(cur));
        end
        if (!first_done) begin
          temp_next[cur]  = bump(temp[cur]);
          first_done_next = 1'b1;
        end
      end
      tlc_pkg::ST_AUTO: begin
        if (blink_timer_next == '0) begin
          blink_timer_next = blink_period;
          lamps_next       = lamps ^ (lamp_bit(1'b0, cur) | lamp_bit(1'b1, cur));
        end
        if (scan_timer_next == '0) begin
          scan_timer_next = scan_period;
          scan_index_next = ~scan_index;
        end
        if (!req.increment_button) begin
          state_next = tlc_pkg::state_t'(tlc_pkg::ST_EDIT_RED + 3'(cur));
        end
        if (repeat_timer_next == '0) begin
          repeat_timer_next = repeat_period;
          temp_next[cur]    = bump(temp[cur]);
        end
      end
      default: begin
        committed_next[cur] = temp[cur];
        if (!req.commit_button) begin
          state_next = tlc_pkg::state_t'(tlc_pkg::ST_EDIT_RED + 3'(cur));
        end
      end
    endcase
  end

  // The display follows the state left by this tick.
  always_comb begin
    result.mode  = state_next;
    result.lamps = lamps_next;
    result.scan  = scan_index_next;
    disp_colour  = edit_colour_next;
    if (state_next == tlc_pkg::ST_EDIT_RED || state_next == tlc_pkg::ST_EDIT_YELLOW ||
        state_next == tlc_pkg::ST_EDIT_GREEN) begin
      disp_colour = tlc_pkg::colour_t'(2'(state_next - tlc_pkg::ST_EDIT_RED));
    end
    unique case (state_next)
      tlc_pkg::ST_INIT: begin
        result.left_value  = '0;
        result.right_value = '0;
      end
      tlc_pkg::ST_RUN: begin
        result.left_value  = way1_count_next[way1_colour_next];
        result.right_value = way2_count_next[way2_colour_next];
      end
      default: begin
        result.left_value  = DW'(tlc_pkg::ST_EDIT_RED) + DW'(disp_colour);
        result.right_value = temp_next[disp_colour];
      end
    endcase
  end

  tlc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .pop       (rsp.valid && rsp.ready),
    .head      (head),
    .status    (fifo_status)
  );

  assign left_digits  = split_digits(head.left_value);
  assign right_digits = split_digits(head.right_value);

  assign rsp.valid       = fifo_status.head_valid;
  assign rsp.mode_code   = head.mode;
  assign rsp.way1_lamps  = head.lamps[2:0];
  assign rsp.way2_lamps  = head.lamps[5:3];
  assign rsp.scan_digit  = head.scan;
  assign rsp.left_tens   = left_digits.tens;
  assign rsp.left_units  = left_digits.units;
  assign rsp.right_tens  = right_digits.tens;
  assign rsp.right_units = right_digits.units;

endmodule

[dv/two_way_traffic_light_controller_top_tb.sv]
// Self-checking testbench for the two-way traffic light controller top level.
module two_way_traffic_light_controller_top_tb;
  import tlc_pkg::*;

  // The run is bounded by a free-running cycle counter whose limit lies above what a correct
  // run needs even with the longest sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to wait after the last result so that a stray extra beat would still be seen.
  localparam int TAIL_CYCLES = 8;

  // One result beat as it appears on the output channel.
  typedef struct packed {
    logic [2:0] mode_code;
    logic [2:0] way1_lamps;
    logic [2:0] way2_lamps;
    logic       scan_digit;
    logic [3:0] left_tens;
    logic [3:0] left_units;
    logic [3:0] right_tens;
    logic [3:0] right_units;
  } tick_result_t;

  // Ways the result side may hold off ready.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_kind_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [TIMER_W-1:0] cfg_data;

  tlc_in_if req_if ();
  tlc_out_if rsp_if ();

  two_way_traffic_light_controller_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predicted controller state. It starts at the reset values and is only ever moved on by
  // accepted input beats and by register writes, mirroring what the block should hold.
  // ---------------------------------------------------------------------------------------
  logic [TIMER_W-1:0] period_ticks [4] = '{10'd100, 10'd25, 10'd50, 10'd25};
  state_t ctl = ST_INIT;
  logic [1:0] edit_col = COL_RED;
  logic press_latch = 1'b0;
  logic first_bump_done = 1'b0;
  logic [DUR_W-1:0] dur_set [3] = '{7'd5, 7'd2, 7'd3};
  logic [DUR_W-1:0] dur_edit [3] = '{7'd5, 7'd2, 7'd3};
  logic [1:0] way_col [2] = '{COL_RED, COL_YELLOW};
  logic [DUR_W-1:0] way_cnt [6] = '{7'd5, 7'd2, 7'd3, 7'd5, 7'd2, 7'd3};
  logic [5:0] lamps = '0;
  logic [TIMER_W-1:0] count_tmr = '0;
  logic [TIMER_W-1:0] blink_tmr = '0;
  logic [TIMER_W-1:0] repeat_tmr = '0;
  logic [TIMER_W-1:0] scan_tmr = '0;
  logic scan_sel = 1'b0;

  // Expected result beats, oldest first.
  tick_result_t expected_results [$];
  tick_result_t want;

  int error_count = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int wrap_count = 0;
  int commit_ticks = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int burst_left = 0;
  stall_kind_t stall_kind = STALL_NONE;
  int stall_left = 0;
  int stall_phase = 0;

  // Lamp bit of one colour of one way; way 1 sits in bits 0..2, way 2 in bits 3..5.
  function automatic logic [5:0] lamp_mask(input int way, input logic [1:0] col);
    return 6'b1 << (way * 3 + col);
  endfunction

  function automatic logic [1:0] edited_colour();
    return (edit_col > COL_GREEN) ? COL_GREEN : edit_col;
  endfunction

  function automatic state_t edit_mode(input logic [1:0] col);
    return state_t'(ST_EDIT_RED + col);
  endfunction

  function automatic void scan_step();
    if (scan_tmr == '0) begin
      scan_tmr = period_ticks[CFG_SCAN_PERIOD];
      scan_sel = ~scan_sel;
    end
  endfunction

  // While editing, both lamps of the edited colour flash together.
  function automatic void blink_step(input logic [1:0] col);
    if (blink_tmr == '0) begin
      blink_tmr = period_ticks[CFG_BLINK_PERIOD];
      lamps = lamps ^ (lamp_mask(0, col) | lamp_mask(1, col));
    end
  endfunction

  // The edited copy wraps from the maximum back to one, green included.
  function automatic void dur_bump(input logic [1:0] col);
    if (dur_edit[col] >= MAX_DURATION) begin
      dur_edit[col] = 7'd1;
      wrap_count++;
    end else begin
      dur_edit[col] = dur_edit[col] + 7'd1;
    end
  endfunction

  function automatic void reload_edit_copy();
    for (int k = 0; k < 3; k++) dur_edit[k] = dur_set[k];
  endfunction

  // A count that runs out reloads from the committed duration and the way moves on.
  function automatic void way_advance(input int w);
    logic [1:0] col;
    int slot;
    col = way_col[w];
    slot = w * 3 + col;
    if (way_cnt[slot] <= 7'd1) begin
      way_cnt[slot] = dur_set[col];
      way_col[w] = (col == COL_GREEN) ? 2'(COL_RED) : col + 2'd1;
    end else begin
      way_cnt[slot] = way_cnt[slot] - 7'd1;
    end
  endfunction

  function automatic void way_light(input int w);
    logic [1:0] col;
    logic [1:0] prev;
    col = way_col[w];
    prev = (col == COL_RED) ? 2'(COL_GREEN) : col - 2'd1;
    lamps = lamps | lamp_mask(w, col);
    lamps = lamps & ~lamp_mask(w, prev);
  endfunction

  // Moves the predicted controller on by one base tick and queues the beat it should give.
  function automatic void predict_tick(input logic m, input logic inc, input logic lng,
                                       input logic cmt);
    logic [1:0] col;
    int lv;
    int rv;
    tick_result_t r;

    // All four timers count down first and rest at zero.
    if (count_tmr != '0) count_tmr--;
    if (blink_tmr != '0) blink_tmr--;
    if (repeat_tmr != '0) repeat_tmr--;
    if (scan_tmr != '0) scan_tmr--;

    case (ctl)
      ST_INIT: begin
        reload_edit_copy();
        for (int k = 0; k < 6; k++) way_cnt[k] = dur_set[k % 3];
        way_col[0] = COL_RED;
        way_col[1] = COL_YELLOW;
        lamps = lamp_mask(0, COL_RED) | lamp_mask(1, COL_YELLOW);
        scan_sel = 1'b0;
        scan_tmr = period_ticks[CFG_SCAN_PERIOD];
        count_tmr = period_ticks[CFG_COUNT_PERIOD];
        ctl = ST_RUN;
      end
      ST_RUN: begin
        scan_step();
        if (count_tmr == '0) begin
          count_tmr = period_ticks[CFG_COUNT_PERIOD];
          way_advance(0);
          way_advance(1);
          way_light(0);
          way_light(1);
        end
        if (!press_latch) begin
          if (m) begin
            ctl = ST_EDIT_RED;
            press_latch = 1'b1;
            blink_tmr = period_ticks[CFG_BLINK_PERIOD];
            reload_edit_copy();
            lamps = '0;
          end
        end else if (!m) begin
          press_latch = 1'b0;
        end
      end
      ST_EDIT_RED, ST_EDIT_YELLOW, ST_EDIT_GREEN: begin
        col = 2'(ctl - ST_EDIT_RED);
        blink_step(col);
        scan_step();
        if (!press_latch) begin
          if (m) begin
            ctl = (col == COL_GREEN) ? ST_INIT : state_t'(ctl + 3'd1);
            press_latch = 1'b1;
            lamps = '0;
          end
        end else if (!m) begin
          press_latch = 1'b0;
        end
        // Commit overrides the mode button, and increment overrides both.
        if (cmt) begin
          ctl = ST_COMMIT;
          edit_col = col;
        end
        if (inc) begin
          ctl = ST_INCR;
          edit_col = col;
          first_bump_done = 1'b0;
        end
      end
      ST_INCR: begin
        col = edited_colour();
        blink_step(col);
        scan_step();
        // Held long wins even when the button itself reads released.
        if (lng) begin
          ctl = ST_AUTO;
          repeat_tmr = period_ticks[CFG_REPEAT_PERIOD];
        end else if (!inc) begin
          ctl = edit_mode(col);
        end
        if (!first_bump_done) begin
          dur_bump(col);
          first_bump_done = 1'b1;
        end
      end
      ST_AUTO: begin
        col = edited_colour();
        blink_step(col);
        scan_step();
        if (!inc) ctl = edit_mode(col);
        if (repeat_tmr == '0) begin
          repeat_tmr = period_ticks[CFG_REPEAT_PERIOD];
          dur_bump(col);
        end
      end
      default: begin
        col = edited_colour();
        dur_set[col] = dur_edit[col];
        if (!cmt) ctl = edit_mode(col);
      end
    endcase

    // The display follows the state directly: zero in init, the two counts in run, and
    // the edit mode number beside the edited copy otherwise.
    if (ctl == ST_INIT) begin
      lv = 0;
      rv = 0;
    end else if (ctl == ST_RUN) begin
      lv = way_cnt[way_col[0] % 3];
      rv = way_cnt[3 + way_col[1] % 3];
    end else begin
      col = (ctl <= ST_EDIT_GREEN) ? 2'(ctl - ST_EDIT_RED) : edited_colour();
      lv = ST_EDIT_RED + col;
      rv = dur_edit[col];
    end
    if (ctl == ST_COMMIT) commit_ticks++;

    r.mode_code = ctl;
    r.way1_lamps = lamps[2:0];
    r.way2_lamps = lamps[5:3];
    r.scan_digit = scan_sel;
    r.left_tens = 4'(lv / 10);
    r.left_units = 4'(lv % 10);
    r.right_tens = 4'(rv / 10);
    r.right_units = 4'(rv % 10);
    expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side. Beats go out in bursts of random length; between bursts valid drops for a
  // random gap, and about one burst in four follows its predecessor with no gap at all.
  // Everything is driven at the falling edge and the handshake is judged at the rising one.
  // ---------------------------------------------------------------------------------------
  task automatic send_tick(input logic m, input logic inc, input logic lng, input logic cmt);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.mode_button <= m;
    req_if.increment_button <= inc;
    req_if.increment_held_long <= lng;
    req_if.commit_button <= cmt;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_tick(m, inc, lng, cmt);
    ticks_sent++;
  endtask

  // Stops the input side and waits until every expected beat has come back.
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TIMER_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_ticks[idx] = val;
  endtask

  // The periods are only changed once the block has gone quiet.
  task automatic write_periods(input logic [TIMER_W-1:0] cnt, input logic [TIMER_W-1:0] blk,
                               input logic [TIMER_W-1:0] rpt, input logic [TIMER_W-1:0] scn);
    settle();
    write_reg(CFG_COUNT_PERIOD, cnt);
    write_reg(CFG_BLINK_PERIOD, blk);
    write_reg(CFG_REPEAT_PERIOD, rpt);
    write_reg(CFG_SCAN_PERIOD, scn);
    settings_used++;
  endtask

  // Mostly short periods so that the timers expire often; now and then any legal value.
  function automatic logic [TIMER_W-1:0] pick_period();
    return ($urandom_range(0, 7) == 0) ? TIMER_W'($urandom_range(0, 1023))
                                       : TIMER_W'($urandom_range(0, 12));
  endfunction

  // Random button activity shaped like a person at the panel: presses that are held for a
  // while and released, long increment holds that drive the auto repeat right through the
  // wrap, commits, plus a share of simultaneous presses and plain noise.
  task automatic drive_button_sequences(input int n);
    int sent;
    int pick;
    int hold;
    int rest;
    logic [3:0] bits;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        hold = $urandom_range(1, 30);
        repeat (hold) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        sent += hold;
      end else if (pick < 40) begin
        hold = $urandom_range(1, 4);
        rest = $urandom_range(1, 3);
        repeat (hold) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        repeat (rest) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        sent += hold + rest;
      end else if (pick < 65) begin
        hold = $urandom_range(1, 6);
        repeat (hold) send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        sent += hold;
        if ($urandom_range(0, 1) == 1) begin
          hold = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 25);
          repeat (hold) send_tick(1'b0, 1'b1, 1'b1, 1'b0);
          sent += hold;
        end
        rest = $urandom_range(1, 3);
        repeat (rest) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        sent += rest;
      end else if (pick < 80) begin
        hold = $urandom_range(1, 4);
        rest = $urandom_range(1, 3);
        repeat (hold) send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        repeat (rest) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        sent += hold + rest;
      end else if (pick < 90) begin
        bits = 4'($urandom_range(0, 15));
        hold = $urandom_range(1, 3);
        repeat (hold) send_tick(bits[3], bits[2], bits[1], bits[0]);
        sent += hold;
      end else begin
        hold = $urandom_range(1, 10);
        for (int k = 0; k < hold; k++) begin
          bits = 4'($urandom_range(0, 15));
          send_tick(bits[3], bits[2], bits[1], bits[0]);
        end
        sent += hold;
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // A short scripted walk through every state and button rule at the reset periods.
  // Each entry is {mode, increment, held long, commit}.
  task automatic test_directed_buttons();
    logic [3:0] script [25];
    script = '{
      4'b0000,  // init loads the defaults and starts running
      4'b0000,
      4'b1000,  // mode press enters red edit
      4'b1000,  // still held, so it must not act again
      4'b0000,  // release is seen
      4'b0100,  // increment press
      4'b0100,  // held: the first increment lands once only
      4'b0010,  // held long with the button reading released goes to auto
      4'b0110,
      4'b0000,  // release drops back to red edit
      4'b0001,  // commit
      4'b0001,  // commit held stays put
      4'b0000,
      4'b1101,  // every button at once: increment wins
      4'b0000,
      4'b0000,  // mode latch clears here
      4'b1000,  // yellow edit
      4'b0000,
      4'b1000,  // green edit
      4'b0000,
      4'b1000,  // green edit wraps round to init, display shows zeros
      4'b1111,  // all buttons high in init still just starts the run
      4'b1111,  // mode still held from before: no edit entry
      4'b0000,
      4'b1010   // fresh mode press enters red edit again
    };
    foreach (script[k]) send_tick(script[k][3], script[k][2], script[k][1], script[k][0]);
  endtask

  task automatic test_default_periods();
    drive_button_sequences(150);
  endtask

  // A zero period must behave as a period of one: every timer fires on every tick.
  task automatic test_zero_periods();
    write_periods('0, '0, '0, '0);
    drive_button_sequences(150);
  endtask

  task automatic test_unit_periods();
    write_periods(10'd1, 10'd1, 10'd1, 10'd1);
    drive_button_sequences(150);
  endtask

  task automatic test_slowest_periods();
    write_periods(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    drive_button_sequences(100);
  endtask

  // Fast countdown with a quick auto repeat, so the ways cycle through all their colours.
  task automatic test_fast_count();
    write_periods(10'd2, 10'd3, 10'd1, 10'd7);
    drive_button_sequences(200);
  endtask

  task automatic test_random_periods();
    repeat (5) begin
      write_periods(pick_period(), pick_period(), pick_period(), pick_period());
      drive_button_sequences(120);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side. Ready follows a pattern of its own: stretches always ready, stretches of
  // coin-toss stalls, and stretches of a regular three-in-seven hold-off.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 2));
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    stall_phase++;
    case (stall_kind)
      STALL_NONE: rsp_if.ready <= 1'b1;
      STALL_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
      default: rsp_if.ready <= (stall_phase % 7) >= 3;
    endcase
  end

  function automatic void check_field(input string name, input logic [3:0] exp_v,
                                      input logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Every beat taken from the block is held against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, mode %0d lamps %0d/%0d", $time,
                 rsp_if.mode_code, rsp_if.way1_lamps, rsp_if.way2_lamps);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("mode_code", 4'(want.mode_code), 4'(rsp_if.mode_code));
        check_field("way1_lamps", 4'(want.way1_lamps), 4'(rsp_if.way1_lamps));
        check_field("way2_lamps", 4'(want.way2_lamps), 4'(rsp_if.way2_lamps));
        check_field("scan_digit", 4'(want.scan_digit), 4'(rsp_if.scan_digit));
        check_field("left_tens", want.left_tens, rsp_if.left_tens);
        check_field("left_units", want.left_units, rsp_if.left_units);
        check_field("right_tens", want.right_tens, rsp_if.right_tens);
        check_field("right_units", want.right_units, rsp_if.right_units);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("two_way_traffic_light_controller_top verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_COUNT_PERIOD;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.mode_button = 1'b0;
    req_if.increment_button = 1'b0;
    req_if.increment_held_long = 1'b0;
    req_if.commit_button = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_buttons();
    test_default_periods();
    test_zero_periods();
    test_unit_periods();
    test_slowest_periods();
    test_fast_count();
    test_random_periods();

    // Let everything come back, then wait out the tail in case the block sends a beat
    // nobody asked for.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_results.size());
      error_count += expected_results.size();
    end

    $display("Sent %0d ticks under %0d period settings and checked %0d result beats.",
             ticks_sent, settings_used, results_checked);
    $display("Edited durations wrapped %0d times and %0d ticks were spent committing.",
             wrap_count, commit_ticks);
    if (error_count == 0) begin
      $display("two_way_traffic_light_controller_top verification clean");
    end else begin
      $display("two_way_traffic_light_controller_top verification failed");
    end
    $finish;
  end

endmodule
